// ===== hw/rtl/avrx_pkg.sv =====
package avrx_pkg;

   localparam int DATA_DEPTH = 4096;
   localparam int ADDR_W     = $clog2(DATA_DEPTH);
   localparam int PC_W       = 22;
   localparam int WORD_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 2 * WORD_W;
   localparam int RSP_DATA_W = 48;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_LDI     = 3'd0;
   localparam kind_type KIND_ADD     = 3'd1;
   localparam kind_type KIND_JMP     = 3'd2;
   localparam kind_type KIND_LDS     = 3'd3;
   localparam kind_type KIND_STS     = 3'd4;
   localparam kind_type KIND_UNKNOWN = 3'd5;

   localparam logic [3:0] OPC_LDI = 4'b1110;
   localparam logic [5:0] OPC_ADD = 6'b000011;
   localparam logic [6:0] OPC_JMP = 7'b1001010;
   localparam logic [6:0] OPC_LDS = 7'b1001000;
   localparam logic [6:0] OPC_STS = 7'b1001001;
   localparam logic [1:0] JMP_TAG = 2'b11;

   // Field positions of the response data word, from the lowest bit up.
   localparam int RSP_PC_LO    = 0;
   localparam int RSP_WROTE    = PC_W;
   localparam int RSP_WADDR_LO = PC_W + 1;
   localparam int RSP_WVAL_LO  = RSP_WADDR_LO + WORD_W;

   function automatic kind_type decode_kind(input logic [WORD_W-1:0] w);
      kind_type k;
      k = KIND_UNKNOWN;
      priority if (w[15:12] == OPC_LDI) begin
         k = KIND_LDI;
      end else if (w[15:10] == OPC_ADD) begin
         k = KIND_ADD;
      end else if (w[15:9] == OPC_JMP && w[3:2] == JMP_TAG) begin
         k = KIND_JMP;
      end else if (w[15:9] == OPC_LDS && w[3:0] == 4'd0) begin
         k = KIND_LDS;
      end else if (w[15:9] == OPC_STS && w[3:0] == 4'd0) begin
         k = KIND_STS;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

endpackage

// ===== hw/rtl/avr_subset_instruction_executor_unit.sv =====
// A request transfer loads the input stage, and the result register is loaded from it
// when it is free, so rsp_tvalid rises once the result register holds the instruction.
// Throughput: one instruction per cycle unless the response stalls; a write is forwarded
// to the next read of the same address, so back-to-back dependent instructions do not stall the memory port.
// Reset: synchronous, active high; clears the program counter and then zeroes the
// 4096-byte data memory, one byte per cycle, with req_tready low until that pass ends.
module avr_subset_instruction_executor_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // first_word [15:0], second_word [31:16]
   input  logic [avrx_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_pc [21:0], wrote [22], write_address [38:23], write_value [46:39], zero [47]
   output logic [avrx_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind [2:0]
   output logic [avrx_pkg::KIND_W-1:0]       rsp_tuser
);
   import avrx_pkg::*;

   logic [BYTE_W-1:0] mem [DATA_DEPTH];

   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   kind_type          s1_kind_ff;
   logic [WORD_W-1:0] s1_first_ff;
   logic [WORD_W-1:0] s1_second_ff;
   logic [BYTE_W-1:0] rd_a_ff, rd_b_ff;
   logic              hit_a_ff, hit_b_ff;
   logic [BYTE_W-1:0] fwd_val_ff;

   logic [RSP_DATA_W-1:0] rsp_data_ff;
   kind_type              rsp_kind_ff;

   logic              accept, advance;
   kind_type          req_kind;
   logic [WORD_W-1:0] req_first, req_second;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

   logic [BYTE_W-1:0] val_a, val_b;
   logic              ex_wrote;
   logic [ADDR_W-1:0] ex_waddr;
   logic [BYTE_W-1:0] ex_wval;
   logic [PC_W-1:0]   ex_pc;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   assign req_first  = req_tdata[WORD_W-1:0];
   assign req_second = req_tdata[REQ_DATA_W-1:WORD_W];
   assign req_kind   = decode_kind(req_first);

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      rd_addr_a = req_second[ADDR_W-1:0];
      rd_addr_b = ADDR_W'({req_first[8], req_first[7:4]});
      unique case (req_kind)
         KIND_ADD: begin
            rd_addr_a = ADDR_W'({req_first[8], req_first[7:4]});
            rd_addr_b = ADDR_W'({req_first[9], req_first[3:0]});
         end
         default: begin
            rd_addr_a = req_second[ADDR_W-1:0];
            rd_addr_b = ADDR_W'(req_first[8:4]);
         end
      endcase
   end

   assign val_a = hit_a_ff ? fwd_val_ff : rd_a_ff;
   assign val_b = hit_b_ff ? fwd_val_ff : rd_b_ff;

   always_comb begin
      ex_wrote = 1'b0;
      ex_waddr = '0;
      ex_wval  = '0;
      ex_pc    = pc_ff;
      unique case (s1_kind_ff)
         KIND_LDI: begin
            ex_wrote = 1'b1;
            ex_waddr = ADDR_W'({1'b1, s1_first_ff[7:4]});
            ex_wval  = {s1_first_ff[11:8], s1_first_ff[3:0]};
            ex_pc    = pc_ff + PC_W'(2);
         end
         KIND_ADD: begin
            ex_wrote = 1'b1;
            ex_waddr = ADDR_W'({s1_first_ff[8], s1_first_ff[7:4]});
            ex_wval  = val_a + val_b;
            ex_pc    = pc_ff + PC_W'(2);
         end
         KIND_JMP: begin
            ex_pc = {s1_first_ff[8], s1_first_ff[7:4], s1_first_ff[0], s1_second_ff};
         end
         KIND_LDS: begin
            ex_wrote = 1'b1;
            ex_waddr = ADDR_W'(s1_first_ff[8:4]);
            ex_wval  = val_a;
            ex_pc    = pc_ff + PC_W'(4);
         end
         KIND_STS: begin
            ex_wrote = 1'b1;
            ex_waddr = s1_second_ff[ADDR_W-1:0];
            ex_wval  = val_b;
            ex_pc    = pc_ff + PC_W'(4);
         end
         default: begin
            ex_wrote = 1'b0;
            ex_pc    = pc_ff;
         end
      endcase
   end

   assign mem_we    = clr_busy_ff || (advance && ex_wrote);
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : ex_waddr;
   assign mem_wdata = clr_busy_ff ? '0 : ex_wval;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_comb begin
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DATA_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      pc_in        = advance ? ex_pc : pc_ff;
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         pc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         pc_ff        <= pc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A write retiring at the same edge as a new read is forwarded to that read.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_kind;
         s1_first_ff  <= req_first;
         s1_second_ff <= req_second;
         hit_a_ff     <= advance && ex_wrote && (ex_waddr == rd_addr_a);
         hit_b_ff     <= advance && ex_wrote && (ex_waddr == rd_addr_b);
         fwd_val_ff   <= ex_wval;
      end
      if (advance) begin
         rsp_kind_ff <= s1_kind_ff;
         rsp_data_ff <= {1'b0, ex_wval, WORD_W'(ex_waddr), ex_wrote, ex_pc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

// ===== hw/rtl/avrx_checker.sv =====
module avrx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [avrx_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [avrx_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [avrx_pkg::KIND_W-1:0]       rsp_tuser
);
   import avrx_pkg::*;

   // The memory clearing pass holds off requests right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during memory clearing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_no_write_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_JMP || rsp_tuser == KIND_UNKNOWN)
      |-> !rsp_tdata[RSP_WROTE] && rsp_tdata[RSP_WVAL_LO-1:RSP_WADDR_LO] == '0
          && rsp_tdata[RSP_WVAL_LO+BYTE_W-1:RSP_WVAL_LO] == '0)
      else $error("jump or unknown opcode reported a write");

   a_ldi_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_LDI
      |-> rsp_tdata[RSP_WROTE] && rsp_tdata[RSP_WADDR_LO+4]
          && rsp_tdata[RSP_WVAL_LO-1:RSP_WADDR_LO+5] == '0)
      else $error("load immediate wrote outside registers 16 to 31");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[RSP_DATA_W-1] && rsp_tuser <= KIND_UNKNOWN)
      else $error("malformed response");

endmodule

bind avr_subset_instruction_executor_unit avrx_checker u_avrx_checker (.*);
